[sv/nmea_sentence_framer_top_defines.svh]
// Assertion macros for the NMEA sentence framer.
`ifndef NMEA_SENTENCE_FRAMER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define NSF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define NSF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NSF_ASSERT_IMP(lbl, ante, cons, msg)
`define NSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[sv/nsf_pkg.sv]
// Shared types and constants of the NMEA sentence framer.
package nsf_pkg;

	localparam int unsigned MAX_SENTENCE_BYTES = 128;
	localparam logic [7:0] MAX_BYTES_B = 8'(MAX_SENTENCE_BYTES);

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	localparam logic [7:0] GGA_MIN_COMMAS = 8'd14;
	localparam logic [7:0] RMC_MIN_COMMAS = 8'd11;
	localparam logic [7:0] GST_COMMAS = 8'd8;
	localparam logic [7:0] GSA_MIN_COMMAS = 8'd17;
	localparam logic [7:0] VTG_MIN_COMMAS = 8'd8;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_HI,
		PH_LO,
		PH_TAIL_A,
		PH_TAIL_B
	} nsf_phase_t;

	typedef enum logic [1:0] {
		ST_GOOD,
		ST_BAD,
		ST_LONG
	} nsf_status_t;

	typedef enum logic [2:0] {
		TY_GGA,
		TY_RMC,
		TY_GST,
		TY_GSA,
		TY_VTG,
		TY_PSTM,
		TY_UNKNOWN
	} nsf_type_t;

	typedef struct packed {
		nsf_status_t status;
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
		logic [7:0] comma_total;
		logic [7:0] sentence_bytes;
		logic [47:0] header;
	} nsf_rec_t;

endpackage

[sv/nsf_if.sv]
// Handshake channels of the NMEA sentence framer.
interface nsf_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

interface nsf_res_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [2:0] sentence_type;
	logic [7:0] computed_sum;
	logic [7:0] received_sum;
	logic [7:0] comma_total;
	logic [7:0] sentence_bytes;
	modport source(output valid, output status, output sentence_type, output computed_sum,
		output received_sum, output comma_total, output sentence_bytes, input ready);
	modport sink(input valid, input status, input sentence_type, input computed_sum,
		input received_sum, input comma_total, input sentence_bytes, output ready);
endinterface

[sv/nsf_front.sv]
// Byte framer: tracks the sentence, XOR sum, commas and header, emits records.
module nsf_front import nsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	nsf_byte_if.sink chars,
	input  logic q_full,
	output logic push,
	output nsf_rec_t rec
);

	nsf_phase_t phase_q, phase_n;
	logic [7:0] xor_q, xor_n;
	logic [7:0] count_q, count_n;
	logic [7:0] commas_q, commas_n;
	logic [47:0] header_q, header_n;
	logic [7:0] accum_q, accum_n;
	logic err_q, err_n;
	logic [7:0] b;
	logic acc;
	logic [4:0] hex;
	logic ok;

	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b0, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b0, 4'(c - 8'h57)};
		return r;
	endfunction

	assign b = chars.data_byte;
	assign chars.ready = !q_full;
	assign acc = chars.valid && chars.ready;
	assign hex = hex_decode(b);

	always_comb begin
		phase_n = phase_q;
		xor_n = xor_q;
		count_n = count_q;
		commas_n = commas_q;
		header_n = header_q;
		accum_n = accum_q;
		err_n = err_q;
		push = 1'b0;
		ok = 1'b0;
		rec = '{status: ST_BAD, computed_sum: xor_q, received_sum: accum_q,
			comma_total: commas_q, sentence_bytes: count_q, header: header_q};
		if (acc) begin
			if (b == CH_DOLLAR) begin
				phase_n = PH_BODY;
				xor_n = '0;
				count_n = 8'd1;
				commas_n = '0;
				header_n = '0;
				accum_n = '0;
				err_n = 1'b0;
			end else if (phase_q != PH_IDLE) begin
				if (count_q >= MAX_BYTES_B) begin
					push = 1'b1;
					rec.status = ST_LONG;
					rec.received_sum = '0;
					rec.sentence_bytes = MAX_BYTES_B;
					phase_n = PH_IDLE;
					xor_n = '0;
					count_n = '0;
					commas_n = '0;
					header_n = '0;
					accum_n = '0;
					err_n = 1'b0;
				end else begin
					count_n = count_q + 8'd1;
					for (int i = 0; i < 6; i++) begin
						if (count_q == 8'(i + 1))
							header_n[i*8 +: 8] = b;
					end
					if (b == CH_COMMA)
						commas_n = commas_q + 8'd1;
					unique case (phase_q)
						PH_BODY: begin
							if (b == CH_STAR)
								phase_n = PH_HI;
							else
								xor_n = xor_q ^ b;
						end
						PH_HI: begin
							accum_n = {hex[3:0], 4'h0};
							err_n = err_q | hex[4];
							phase_n = PH_LO;
						end
						PH_LO: begin
							accum_n = {accum_q[7:4], hex[3:0]};
							err_n = err_q | hex[4];
							phase_n = PH_TAIL_A;
						end
						PH_TAIL_A: begin
							phase_n = PH_TAIL_B;
						end
						PH_TAIL_B: begin
							ok = !err_q && (accum_q == xor_q);
							push = 1'b1;
							rec.status = ok ? ST_GOOD : ST_BAD;
							rec.comma_total = commas_n;
							rec.sentence_bytes = count_n;
							rec.header = header_n;
							phase_n = PH_IDLE;
							xor_n = '0;
							count_n = '0;
							commas_n = '0;
							header_n = '0;
							accum_n = '0;
							err_n = 1'b0;
						end
						default: begin
							phase_n = PH_IDLE;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			xor_q <= '0;
			count_q <= '0;
			commas_q <= '0;
			header_q <= '0;
			accum_q <= '0;
			err_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			xor_q <= xor_n;
			count_q <= count_n;
			commas_q <= commas_n;
			header_q <= header_n;
			accum_q <= accum_n;
			err_q <= err_n;
		end
	end

endmodule

[sv/nsf_fifo.sv]
// Short record queue between the framer and the reporting stage.
module nsf_fifo import nsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  nsf_rec_t wdata,
	output logic full,
	input  logic pop,
	output nsf_rec_t rdata,
	output logic empty
);

	nsf_rec_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0] cnt_q;

	function automatic logic [FIFO_AW-1:0] bump(input logic [FIFO_AW-1:0] p);
		return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_AW'(1);
	endfunction

	assign full = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= bump(wr_q);
			if (pop)
				rd_q <= bump(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + (FIFO_AW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (FIFO_AW+1)'(1);
		end
	end

endmodule

[sv/nsf_back.sv]
// Reporting stage: sentence type lookup and registered result output.
module nsf_back import nsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  nsf_rec_t head,
	output logic pop,
	nsf_res_if.source results
);

	logic vld_q;
	nsf_status_t status_q;
	nsf_type_t type_q;
	logic [7:0] csum_q, rsum_q, commas_q, nbytes_q;
	nsf_type_t ty;

	function automatic logic tag_is(input logic [47:0] h, input logic [7:0] a,
		input logic [7:0] b, input logic [7:0] c);
		return h[23:16] == a && h[31:24] == b && h[39:32] == c && h[47:40] == CH_COMMA;
	endfunction

	always_comb begin
		logic [7:0] c;
		c = head.comma_total;
		priority if (tag_is(head.header, "G", "G", "A") && c >= GGA_MIN_COMMAS)
			ty = TY_GGA;
		else if (tag_is(head.header, "R", "M", "C") && c >= RMC_MIN_COMMAS)
			ty = TY_RMC;
		else if (tag_is(head.header, "G", "S", "T") && c == GST_COMMAS)
			ty = TY_GST;
		else if (tag_is(head.header, "G", "S", "A") && c >= GSA_MIN_COMMAS)
			ty = TY_GSA;
		else if (tag_is(head.header, "V", "T", "G") && c >= VTG_MIN_COMMAS)
			ty = TY_VTG;
		else if (head.header[7:0] == "P" && head.header[15:8] == "S"
			&& head.header[23:16] == "T" && head.header[31:24] == "M"
			&& head.header[39:32] == CH_COMMA)
			ty = TY_PSTM;
		else
			ty = TY_UNKNOWN;
	end

	assign pop = !q_empty && (!vld_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (results.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= head.status;
			type_q <= (head.status == ST_GOOD) ? ty : TY_UNKNOWN;
			csum_q <= head.computed_sum;
			rsum_q <= head.received_sum;
			commas_q <= head.comma_total;
			nbytes_q <= head.sentence_bytes;
		end
	end

	assign results.valid = vld_q;
	assign results.status = status_q;
	assign results.sentence_type = type_q;
	assign results.computed_sum = csum_q;
	assign results.received_sum = rsum_q;
	assign results.comma_total = commas_q;
	assign results.sentence_bytes = nbytes_q;

endmodule

[sv/nmea_sentence_framer_top.sv]
// NMEA 0183 sentence framer top level.
// Takes one character per cycle and reports one result per sentence: checksum
// good/bad or too long, both sums, comma and byte counts and the sentence type.
// A result is written into the result queue when its last tail byte is taken
// and goes valid from the result register once it is popped. The framer runs at
// one byte per cycle; input stalls only when the four-entry result queue is
// full, which happens only if the result side holds ready low long enough.
`include "nmea_sentence_framer_top_defines.svh"
module nmea_sentence_framer_top import nsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	nsf_byte_if.sink chars,
	nsf_res_if.source results
);

	logic push, pop, q_full, q_empty;
	nsf_rec_t wrec, head;

	nsf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.q_full(q_full),
		.push(push),
		.rec(wrec)
	);

	nsf_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(wrec),
		.full(q_full),
		.pop(pop),
		.rdata(head),
		.empty(q_empty)
	);

	nsf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.head(head),
		.pop(pop),
		.results(results)
	);

	`NSF_ASSERT_IMP(a_no_overflow, push, !q_full, "record pushed into full queue")
	`NSF_ASSERT_IMP(a_type_unknown,
		results.valid && results.status != ST_GOOD,
		results.sentence_type == TY_UNKNOWN, "type set on failed sentence")
	`NSF_ASSERT_IMP(a_good_sums,
		results.valid && results.status == ST_GOOD,
		results.computed_sum == results.received_sum, "good status with differing sums")
	`NSF_ASSERT_NXT(a_pop_shows, pop, results.valid, "popped record not presented")

endmodule
